// ===== rtl/sitda_pkg.sv =====
// Package: shared types, constants and the power-of-ten table of the decimal converter.
`timescale 1ns / 1ps

package sitda_pkg;

  // Field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW  = 8;

  // Digit positions, 10^9 down to 10^0
  localparam int unsigned NumPow = 10;
  localparam int unsigned PowIdxW = $clog2(NumPow);

  // Binary search over the digit: weights 8, 4, 2, 1
  localparam int unsigned BitIdxW = 2;

  // Width of a weighted power of ten (8 * 10^9 needs 33 bits)
  localparam int unsigned MultW = 34;

  // Character codes
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;

  // Result of one compare-subtract step
  typedef struct packed {
    logic              ge;
    logic [ValueW-1:0] rem;
  } cmpsub_res_t;

  // 10^p for p = 0..9
  function automatic logic [ValueW-1:0] pow10(input logic [PowIdxW-1:0] p);
    logic [ValueW-1:0] r;
    unique case (p)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      4'd9:    r = 32'd1000000000;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // (2^b) * 10^p, widened so 8 * 10^9 does not wrap
  function automatic logic [MultW-1:0] weight(input logic [PowIdxW-1:0] p,
                                              input logic [BitIdxW-1:0] b);
    logic [MultW-1:0] w;
    w = {{(MultW-ValueW){1'b0}}, pow10(p)} << b;
    return w;
  endfunction

endpackage

// ===== rtl/sitda_if.sv =====
// Interfaces: valid/ready channels for the input value and the output characters.
`timescale 1ns / 1ps

interface sitda_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sitda_pkg::ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
  logic                         valid;
  logic                         ready;
  logic [sitda_pkg::CharW-1:0]  character;
  logic                         last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/sitda_cmpsub.sv =====
// Shared compare-subtract unit: tests the magnitude against (2^b) * 10^p and reduces it.
`timescale 1ns / 1ps

module sitda_cmpsub (
  input  logic [sitda_pkg::ValueW-1:0]  mag_i,
  input  logic [sitda_pkg::PowIdxW-1:0] pidx_i,
  input  logic [sitda_pkg::BitIdxW-1:0] bidx_i,
  output sitda_pkg::cmpsub_res_t        res_o
);

  logic [sitda_pkg::MultW-1:0] w;
  logic [sitda_pkg::MultW-1:0] mag_ext;

  // One wide compare, one subtract; the low bits suffice when the compare passes
  always_comb begin
    w          = sitda_pkg::weight(pidx_i, bidx_i);
    mag_ext    = {{(sitda_pkg::MultW-sitda_pkg::ValueW){1'b0}}, mag_i};
    res_o.ge   = (mag_ext >= w);
    res_o.rem  = res_o.ge ? (mag_i - w[sitda_pkg::ValueW-1:0]) : mag_i;
  end

endmodule

// ===== rtl/signed_int_to_decimal_ascii_top.sv =====
// Top level: signed 32-bit integer to decimal ASCII, one character per transfer.
// Flow: the '-' is registered from the sign state after the input transfer; each decimal
// position runs the compare-subtract steps for weights 8, 4, 2, 1 from 10^9 down, and its
// digit is registered when the last step completes, leading zeros skipped but for 10^0.
// A new value is taken only in idle, after the last digit is placed; output stalls hold it.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and empties the output.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  sitda_in_if.sink           in_i,
  sitda_out_if.source        out_o
);

  typedef enum logic [1:0] {
    StIdle,
    StSign,
    StConv
  } state_e;

  state_e                          state_q, state_d;
  logic [sitda_pkg::ValueW-1:0]    mag_q, mag_d;
  logic [sitda_pkg::PowIdxW-1:0]   pidx_q, pidx_d;
  logic [sitda_pkg::BitIdxW-1:0]   bidx_q, bidx_d;
  logic [3:0]                      digit_q, digit_d;
  logic                            started_q, started_d;
  logic                            ovalid_q, ovalid_d;
  logic [sitda_pkg::CharW-1:0]     ochar_q, ochar_d;
  logic                            olast_q, olast_d;

  sitda_pkg::cmpsub_res_t          cs;
  logic                            slot_free;
  logic [3:0]                      dnext;
  logic                            emit;

  sitda_cmpsub u_cmpsub (
    .mag_i  (mag_q),
    .pidx_i (pidx_q),
    .bidx_i (bidx_q),
    .res_o  (cs)
  );

  assign in_i.ready      = (state_q == StIdle);
  assign out_o.valid     = ovalid_q;
  assign out_o.character = ochar_q;
  assign out_o.last      = olast_q;

  assign slot_free = !ovalid_q || out_o.ready;
  assign dnext     = digit_q | ({3'b000, cs.ge} << bidx_q);
  assign emit      = started_q || (dnext != 4'd0) || (pidx_q == '0);

  // Sequencer and output register
  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    pidx_d    = pidx_q;
    bidx_d    = bidx_q;
    digit_d   = digit_q;
    started_d = started_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    ochar_d   = ochar_q;
    olast_d   = olast_q;

    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          mag_d     = in_i.value[sitda_pkg::ValueW-1]
                      ? (~in_i.value + 1'b1) : in_i.value;
          pidx_d    = sitda_pkg::PowIdxW'(sitda_pkg::NumPow - 1);
          bidx_d    = '1;
          digit_d   = '0;
          started_d = 1'b0;
          state_d   = in_i.value[sitda_pkg::ValueW-1] ? StSign : StConv;
        end
      end
      StSign: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ochar_d  = sitda_pkg::CharMinus;
          olast_d  = 1'b0;
          state_d  = StConv;
        end
      end
      StConv: begin
        if (bidx_q != '0) begin
          // inner step of the binary search on this digit
          mag_d   = cs.rem;
          digit_d = dnext;
          bidx_d  = bidx_q - 1'b1;
        end else if (!emit || slot_free) begin
          // digit complete: hold here while a wanted character cannot be placed
          mag_d     = cs.rem;
          digit_d   = '0;
          bidx_d    = '1;
          started_d = started_q || emit;
          if (emit) begin
            ovalid_d = 1'b1;
            ochar_d  = sitda_pkg::CharZero | {4'h0, dnext};
            olast_d  = (pidx_q == '0);
          end
          if (pidx_q == '0) begin
            state_d = StIdle;
          end else begin
            pidx_d = pidx_q - 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer state, working registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      mag_q     <= '0;
      pidx_q    <= '0;
      bidx_q    <= '0;
      digit_q   <= '0;
      started_q <= 1'b0;
      ovalid_q  <= 1'b0;
      ochar_q   <= '0;
      olast_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      mag_q     <= mag_d;
      pidx_q    <= pidx_d;
      bidx_q    <= bidx_d;
      digit_q   <= digit_d;
      started_q <= started_d;
      ovalid_q  <= ovalid_d;
      ochar_q   <= ochar_d;
      olast_q   <= olast_d;
    end
  end

endmodule

// ===== rtl/sitda_checker.sv =====
// Checker: port-level assertions on the decimal converter, bound to the top level.
`timescale 1ns / 1ps

module sitda_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [sitda_pkg::CharW-1:0]  out_char_i,
  input logic                         out_last_i
);

  // Every character shown is a minus sign or a decimal digit
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_char_i == sitda_pkg::CharMinus) ||
                    ((out_char_i >= sitda_pkg::CharZero) &&
                     (out_char_i <= (sitda_pkg::CharZero + 8'd9))))
    else $error("illegal output character");

  // A minus sign never ends a run
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_char_i == sitda_pkg::CharMinus)) |-> !out_last_i)
    else $error("minus sign flagged last");

  // Input side busy straight after a transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after a transfer");

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_char_i) && $stable(out_last_i)))
    else $error("stalled output changed");

endmodule

bind signed_int_to_decimal_ascii_top sitda_checker u_sitda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.character),
  .out_last_i  (out_o.last)
);

// ===== tb/testbench.sv =====
// Testbench: drives signed integers into the decimal converter and checks every character.
`timescale 1ns / 1ps

module testbench;

  localparam int DirRows    = 25;
  localparam int RandItems  = 235;
  localparam int MaxWait    = 7;
  localparam int TailCycles = 100;
  localparam int QuietLimit = 2000;

  // One expected output character
  typedef struct {
    logic [sitda_pkg::CharW-1:0] character;
    logic                        last;
  } char_beat_t;

  logic clk_i;
  logic rst_ni;

  sitda_in_if  in_if ();
  sitda_out_if out_if ();

  signed_int_to_decimal_ascii_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Directed rows; an empty text means the predictor supplies the characters
  logic signed [sitda_pkg::ValueW-1:0] dir_value [DirRows] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd10, 32'sd99, 32'sd100, -32'sd999,
    32'sd1000, 32'sd12345, -32'sd100000, 32'sd999999, 32'sd1000000, -32'sd9999999,
    32'sd10000000, 32'sd99999999, -32'sd100000000, 32'sd999999999, 32'sd1000000000,
    32'sh7FFF_FFFF, 32'sh8000_0001, 32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA,
    -32'sd123456789
  };
  string dir_text [DirRows] = '{
    "0", "1", "-1", "9", "-10", "", "", "",
    "", "", "", "", "", "",
    "", "", "", "", "1000000000",
    "2147483647", "-2147483647", "-2147483648", "", "",
    ""
  };

  logic signed [sitda_pkg::ValueW-1:0] stim_value [$];
  string                               stim_text  [$];
  char_beat_t                          expected_chars [$];

  int  errors      = 0;
  int  accepted_in = 0;
  int  quiet_count = 0;
  bit  calm        = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predictor: decimal text of a two's complement value, most significant first
  function automatic void queue_decimal_text(input logic [sitda_pkg::ValueW-1:0] raw);
    logic                        neg;
    logic [sitda_pkg::ValueW-1:0] mag;
    logic [sitda_pkg::CharW-1:0] digits [10];
    int                          nd;
    int                          i;
    neg = raw[sitda_pkg::ValueW-1];
    mag = neg ? (32'd0 - raw) : raw;
    nd  = 0;
    // at least one digit, even for zero
    do begin
      digits[nd] = sitda_pkg::CharZero + sitda_pkg::CharW'(mag % 32'd10);
      nd++;
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    if (neg) expected_chars.push_back('{character: sitda_pkg::CharMinus, last: 1'b0});
    for (i = nd - 1; i >= 0; i--)
      expected_chars.push_back('{character: digits[i], last: (i == 0)});
  endfunction

  // Typed-in text of a directed row
  function automatic void queue_typed_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      expected_chars.push_back('{character: s[i], last: (i == s.len() - 1)});
  endfunction

  // Idle cycles before the next transfer; none during calm stretches
  function automatic int draw_wait();
    int n;
    n = calm ? 0 : $urandom_range(0, MaxWait);
    return n;
  endfunction

  // Random value: full range, short digit runs, near the extremes, around powers of ten
  function automatic logic [sitda_pkg::ValueW-1:0] rand_value();
    logic [sitda_pkg::ValueW-1:0] v;
    logic [sitda_pkg::ValueW-1:0] p;
    int                           len;
    int                           k;
    v = 32'd0;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom();
      2, 3: begin
        len = $urandom_range(1, 9);
        p   = 32'd1;
        for (k = 0; k < len; k++) p = p * 32'd10;
        v = $urandom_range(0, p - 32'd1);
      end
      4: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 15)
                                  : 32'h8000_0000 + $urandom_range(0, 15);
      default: begin
        len = $urandom_range(0, 9);
        p   = 32'd1;
        for (k = 0; k < len; k++) p = p * 32'd10;
        v = p + $urandom_range(0, 2) - 32'd1;
      end
    endcase
    if (v != 32'h8000_0000 && $urandom_range(0, 1)) v = 32'd0 - v;
    return v;
  endfunction

  // Input transfers: queue the expected characters
  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      if (stim_text[accepted_in].len() != 0) queue_typed_text(stim_text[accepted_in]);
      else queue_decimal_text(in_if.value);
      accepted_in++;
      calm = ((accepted_in / 30) % 3) == 2;
    end
  end

  // Output transfers: compare with the oldest expectation
  always @(posedge clk_i) begin : check_output
    char_beat_t want;
    if (out_if.valid && out_if.ready) begin
      if (expected_chars.size() == 0) begin
        errors++;
        $error("unexpected character %h (last %b)", out_if.character, out_if.last);
      end else begin
        want = expected_chars.pop_front();
        if (out_if.character !== want.character) begin
          errors++;
          $error("character: expected %h, actual %h", want.character, out_if.character);
        end
        if (out_if.last !== want.last) begin
          errors++;
          $error("last: expected %b, actual %b", want.last, out_if.last);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_count <= 0;
    else quiet_count <= quiet_count + 1;
    if (quiet_count >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls between character transfers
  initial begin : drive_ready
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Sender and run control
  initial begin : drive_values
    int gap;
    int n;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.value  <= '0;
    for (n = 0; n < DirRows; n++) begin
      stim_value.push_back(dir_value[n]);
      stim_text.push_back(dir_text[n]);
    end
    for (n = 0; n < RandItems; n++) begin
      stim_value.push_back(rand_value());
      stim_text.push_back("");
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // one transfer per item; valid stays high across back-to-back items
    for (n = 0; n < stim_value.size(); n++) begin
      gap = draw_wait();
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_if.valid <= 1'b1;
      in_if.value <= stim_value[n];
      do @(posedge clk_i); while (!in_if.ready);
    end
    in_if.valid <= 1'b0;
    // let the last transfer queue its characters, drain, then allow for stray output
    @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sitda_pkg.sv
rtl/sitda_if.sv
rtl/sitda_cmpsub.sv
rtl/signed_int_to_decimal_ascii_top.sv
rtl/sitda_checker.sv
tb/testbench.sv
